/* design/amwf_pkg.sv */
// ---------------------------------------------------------------------------
// amwf_pkg
// Shared types and constants for the adaptive MMSE window filter.
// ---------------------------------------------------------------------------
`default_nettype none

package amwf_pkg;

  // Default sizes
  localparam int DEF_MAX_HALF_WINDOW = 10;
  localparam int DEF_MAX_LINE_PIXELS = 2048;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_WINDOW = 2'd0;
  localparam logic [1:0] CFG_NOISE_VAR   = 2'd1;
  localparam logic [1:0] CFG_IMG_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_IMG_HEIGHT  = 2'd3;

  // Fixed widths (sized for the largest window, 21 x 21)
  localparam int HW_W  = 4;   // half window register
  localparam int TW_W  = 5;   // 2h and window counters
  localparam int N_W   = 9;   // pixels per window
  localparam int S_W   = 17;  // channel sum
  localparam int Q_W   = 25;  // channel sum of squares
  localparam int D_W   = 34;  // n*Q - S*S
  localparam int AR_W  = 48;  // signed working width of numerator/denominator

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_SUB,
    ST_PROD,
    ST_NUM,
    ST_CHK,
    ST_DIV,
    ST_CH,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic scan_rd;
    logic calc_mul;
    logic calc_sub;
    logic calc_prod;
    logic calc_num;
    logic div_chk;
    logic div_step;
    logic ch_adv;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic produce;
    logic scan_last;
    logic div_last;
    logic ch_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* design/amwf_ctrl.sv */
// ---------------------------------------------------------------------------
// amwf_ctrl
// Sequencer: window scan, per-channel arithmetic steps, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module amwf_ctrl
  import amwf_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.produce) state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_MUL;
      ST_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = ST_SUB;
      end
      ST_SUB: begin
        cmd.calc_sub = 1'b1;
        state_nxt    = ST_PROD;
      end
      ST_PROD: begin
        cmd.calc_prod = 1'b1;
        state_nxt     = ST_NUM;
      end
      ST_NUM: begin
        cmd.calc_num = 1'b1;
        state_nxt    = ST_CHK;
      end
      ST_CHK: begin
        cmd.div_chk = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_CH;
      end
      ST_CH: begin
        cmd.ch_adv = 1'b1;
        state_nxt  = sts.ch_last ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/amwf_dp.sv */
// ---------------------------------------------------------------------------
// amwf_dp
// Datapath: config, raster counters, line store, window sums, gain and
// rounding arithmetic with an 8-step quotient unit, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module amwf_dp
  import amwf_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire  [7:0]  in_red_in,
  input  wire  [7:0]  in_green_in,
  input  wire  [7:0]  in_blue_in,
  input  wire         out_stall,
  output logic        out_valid,
  output logic [10:0] out_center_x,
  output logic [15:0] out_center_y,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  input  cmd_t        cmd,
  output sts_t        sts
);

  localparam int STORE_LINES = 2 * MAX_HALF_WINDOW + 1;
  localparam int SLW         = $clog2(STORE_LINES);
  localparam int CW          = $clog2(MAX_LINE_PIXELS) + 1;
  localparam int AW          = CW - 1;

  // configuration registers
  logic [HW_W-1:0] cfg_hw_r;
  logic [15:0]     cfg_nv_r;
  logic [11:0]     cfg_w_r;
  logic [15:0]     cfg_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hw_r <= HW_W'(2);
      cfg_nv_r <= 16'd5;
      cfg_w_r  <= 12'd2048;
      cfg_h_r  <= 16'd1080;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_WINDOW: cfg_hw_r <= cfg_data[HW_W-1:0];
        CFG_NOISE_VAR:   cfg_nv_r <= cfg_data;
        CFG_IMG_WIDTH:   cfg_w_r  <= cfg_data[11:0];
        CFG_IMG_HEIGHT:  cfg_h_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective (clamped) settings
  logic [HW_W-1:0] hw;
  logic [TW_W-1:0] tw;
  logic [15:0]     nv;
  logic [CW-1:0]   wid;
  logic [15:0]     hgt;

  always_comb begin
    hw  = (32'(cfg_hw_r) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW) : cfg_hw_r;
    tw  = {hw, 1'b0};
    nv  = (cfg_nv_r == 16'd0) ? 16'd1 : cfg_nv_r;
    if (cfg_w_r == 12'd0)                     wid = CW'(1);
    else if (32'(cfg_w_r) > MAX_LINE_PIXELS)  wid = CW'(MAX_LINE_PIXELS);
    else                                      wid = CW'(cfg_w_r);
    hgt = (cfg_h_r == 16'd0) ? 16'd1 : cfg_h_r;
  end

  // raster position
  logic [CW-1:0]  col_r, col_nxt;
  logic [15:0]    row_r, row_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;
  logic [CW-1:0]  c0, c1;
  logic [15:0]    r0;
  logic [16:0]    r1;
  logic [SLW-1:0] s0, s1;
  logic           produce;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    return (s == SLW'(STORE_LINES - 1)) ? '0 : s + SLW'(1);
  endfunction

  always_comb begin
    c0 = col_r;
    r0 = row_r;
    s0 = slot_r;
    if (c0 >= wid) begin
      c0 = '0;
      r0 = row_r + 16'd1;
      s0 = slot_inc(slot_r);
    end
    if (r0 >= hgt) begin
      r0 = '0;
      s0 = '0;
    end
    produce = (r0 >= 16'(tw)) && (c0 >= CW'(tw));
    c1       = c0 + CW'(1);
    col_nxt  = c1;
    row_nxt  = r0;
    slot_nxt = s0;
    r1       = 17'(r0) + 17'd1;
    s1       = slot_inc(s0);
    if (c1 >= wid) begin
      col_nxt  = '0;
      row_nxt  = r1[15:0];
      slot_nxt = s1;
      if (r1 >= 17'(hgt)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (cmd.take) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // window origin
  logic [SLW:0]   slot_tmp;
  logic [SLW-1:0] slot_start;
  logic [CW-1:0]  col_start;

  always_comb begin
    slot_tmp   = (s0 < SLW'(tw)) ? ((SLW+1)'(s0) + (SLW+1)'(STORE_LINES) - (SLW+1)'(tw))
                                 : ((SLW+1)'(s0) - (SLW+1)'(tw));
    slot_start = slot_tmp[SLW-1:0];
    col_start  = c0 - CW'(tw);
  end

  // line store
  logic [23:0] store_mem [STORE_LINES][MAX_LINE_PIXELS];
  logic [23:0] rd_data_r;
  logic [SLW-1:0] rd_slot_r;
  logic [CW-1:0]  rd_col_r, base_col_r;
  logic [TW_W-1:0] rr_r, cc_r;
  logic           rd_vld_r, rd_ctr_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      store_mem[s0][c0[AW-1:0]] <= {in_red_in, in_green_in, in_blue_in};
    end
    if (cmd.scan_rd) begin
      rd_data_r <= store_mem[rd_slot_r][rd_col_r[AW-1:0]];
    end
  end

  // scan counters
  logic scan_last;
  assign scan_last = (rr_r == tw) && (cc_r == tw);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rr_r       <= '0;
      cc_r       <= '0;
      rd_slot_r  <= slot_start;
      rd_col_r   <= col_start;
      base_col_r <= col_start;
    end else if (cmd.scan_rd) begin
      if (cc_r == tw) begin
        cc_r      <= '0;
        rr_r      <= rr_r + TW_W'(1);
        rd_col_r  <= base_col_r;
        rd_slot_r <= slot_inc(rd_slot_r);
      end else begin
        cc_r     <= cc_r + TW_W'(1);
        rd_col_r <= rd_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_ctr_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      rd_ctr_r <= cmd.scan_rd && (rr_r == TW_W'(hw)) && (cc_r == TW_W'(hw));
    end
  end

  // window sums and center pixel
  logic [S_W-1:0] sum_r [3];
  logic [Q_W-1:0] sq_r  [3];
  logic [7:0]     src_r [3];
  logic [7:0]     px    [3];
  logic [N_W-1:0] n_r;
  logic [CW-1:0]  cx_r;
  logic [15:0]    cy_r;
  logic [TW_W-1:0] side;

  assign px[0] = rd_data_r[23:16];
  assign px[1] = rd_data_r[15:8];
  assign px[2] = rd_data_r[7:0];
  assign side  = tw + TW_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      n_r  <= N_W'(side) * N_W'(side);
      cx_r <= c0 - CW'(hw);
      cy_r <= r0 - 16'(hw);
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.take) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end else if (rd_vld_r) begin
        sum_r[i] <= sum_r[i] + S_W'(px[i]);
        sq_r[i]  <= sq_r[i] + Q_W'(px[i]) * Q_W'(px[i]);
      end
      if (rd_ctr_r) src_r[i] <= px[i];
    end
  end

  // channel arithmetic
  logic [1:0]           ch_r;
  logic [S_W-1:0]       s_sel;
  logic [Q_W-1:0]       q_sel;
  logic [7:0]           src_sel;
  logic [D_W-1:0]       p1_r, p2_r, d_r;
  logic [N_W+15:0]      p3_r;
  logic [S_W-1:0]       p4_r;
  logic signed [S_W:0]  t_r;
  logic [D_W+7:0]       a_r;
  logic signed [N_W+S_W+16:0] b_r;
  logic signed [AR_W-1:0] m_v, num_r, den_r, rem_r, dsh_r;
  logic [7:0]           q_r;
  logic [2:0]           dcnt_r;
  logic                 neg_r, sat_r;
  logic [7:0]           res_r [3];

  assign s_sel   = sum_r[ch_r];
  assign q_sel   = sq_r[ch_r];
  assign src_sel = src_r[ch_r];
  assign m_v     = AR_W'(a_r) + AR_W'(b_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_mul) begin
      p1_r <= D_W'(n_r) * D_W'(q_sel);
      p2_r <= D_W'(s_sel) * D_W'(s_sel);
      p3_r <= (N_W+16)'(nv) * (N_W+16)'(n_r);
      p4_r <= S_W'(n_r) * S_W'(src_sel);
    end
    if (cmd.calc_sub) begin
      d_r <= p1_r - p2_r;
      t_r <= $signed({1'b0, s_sel}) - $signed({1'b0, p4_r});
    end
    if (cmd.calc_prod) begin
      a_r <= (D_W+8)'(src_sel) * (D_W+8)'(d_r);
      b_r <= (N_W+S_W+17)'($signed({1'b0, p3_r})) * (N_W+S_W+17)'(t_r);
    end
    if (cmd.calc_num) begin
      if (d_r == '0) begin
        num_r <= AR_W'({s_sel, 1'b0}) + AR_W'(n_r);
        den_r <= AR_W'({n_r, 1'b0});
      end else begin
        num_r <= (m_v <<< 1) + AR_W'(d_r);
        den_r <= AR_W'({d_r, 1'b0});
      end
    end
    if (cmd.div_chk) begin
      neg_r <= num_r < 0;
      sat_r <= num_r >= (den_r <<< 8);
      rem_r <= num_r;
      dsh_r <= den_r <<< 7;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        q_r   <= {q_r[6:0], 1'b0};
      end
      dsh_r <= dsh_r >>> 1;
    end
    if (cmd.ch_adv) begin
      res_r[ch_r] <= neg_r ? 8'd0 : (sat_r ? 8'd255 : q_r);
    end
  end

  // division step and channel counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      ch_r   <= '0;
    end else begin
      if (cmd.div_chk)       dcnt_r <= 3'd7;
      else if (cmd.div_step) dcnt_r <= dcnt_r - 3'd1;
      if (cmd.take)          ch_r <= '0;
      else if (cmd.ch_adv)   ch_r <= ch_r + 2'd1;
    end
  end

  // result register
  logic        out_valid_r;
  logic [31:0] cx32;

  assign cx32 = 32'(cx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_center_x  <= cx32[10:0];
      out_center_y  <= cy_r;
      out_red_out   <= res_r[0];
      out_green_out <= res_r[1];
      out_blue_out  <= res_r[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.produce   = produce;
  assign sts.scan_last = scan_last;
  assign sts.div_last  = (dcnt_r == 3'd0);
  assign sts.ch_last   = (ch_r == 2'd2);
  assign sts.out_busy  = out_valid_r && out_stall;

  // checks
  a_rd_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(cmd.scan_rd)) else $error("read data without a read");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r) else $error("result not presented");
  a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (rr_r == '0) && (cc_r == '0) && (ch_r == '0))
    else $error("scan not restarted");
  a_no_take_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !cmd.scan_rd && !cmd.div_step) else $error("take during work");

endmodule

`default_nettype wire

/* design/adaptive_mmse_window_filter.sv */
// ---------------------------------------------------------------------------
// adaptive_mmse_window_filter
// Lee adaptive MMSE filter over a raster RGB stream using a line store.
// ---------------------------------------------------------------------------
// A pixel whose window is not yet complete is only written to the line
// store. A pixel that completes the (2h+1)x(2h+1) window around an
// interior center holds the input stalled while one line-store read port
// fetches the window one pixel per cycle, then each of the three channels
// goes through four multiply/add steps, a range check and an 8-step quotient
// unit. A finished result waits in the output register while the next pixel is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module adaptive_mmse_window_filter
  import amwf_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  parameter int MAX_LINE_PIXELS = DEF_MAX_LINE_PIXELS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_red_in,
  input  wire  [7:0]  in_green_in,
  input  wire  [7:0]  in_blue_in,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [10:0] out_center_x,
  output logic [15:0] out_center_y,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out
);

  cmd_t cmd;
  sts_t sts;

  amwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  amwf_dp #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_center_x  (out_center_x),
    .out_center_y  (out_center_y),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

/* dv/amwf_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amwf_checker
// Watches the pixel, result and register ports of the MMSE window filter,
// keeps its own copy of the line store and counters, predicts each filtered
// pixel and compares every result request against the oldest prediction.
// ---------------------------------------------------------------------------

module amwf_checker
  import amwf_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [7:0]  in_red_in,
  input  wire  [7:0]  in_green_in,
  input  wire  [7:0]  in_blue_in,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [10:0] out_center_x,
  input  wire  [15:0] out_center_y,
  input  wire  [7:0]  out_red_out,
  input  wire  [7:0]  out_green_out,
  input  wire  [7:0]  out_blue_out,
  output int          mismatches,
  output int          pending
);

  localparam int ROWS  = 2 * DEF_MAX_HALF_WINDOW + 1;
  localparam int LINEW = DEF_MAX_LINE_PIXELS;

  typedef struct packed {
    logic [10:0] cx;
    logic [15:0] cy;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } filtered_px_t;

  logic [23:0]  pixel_mem [0:ROWS*LINEW-1];
  filtered_px_t filtered_q [$];
  int           col_cnt, row_cnt;
  logic [3:0]   reg_hw;
  logic [15:0]  reg_noise;
  logic [11:0]  reg_width;
  logic [15:0]  reg_height;

  function automatic longint fdiv(longint a, longint b);
    longint qt;
    qt = a / b;
    if ((a % b) != 0 && a < 0) qt = qt - 1;
    return qt;
  endfunction

  // Lee gain applied to one channel, rounded half up and clamped
  function automatic logic [7:0] lee_channel(longint s, longint q, longint n,
                                             longint src, longint nv);
    longint d, m, v;
    d = n * q - s * s;
    if (d <= 0) v = fdiv(2 * s + n, 2 * n);
    else begin
      m = src * d + nv * n * (s - n * src);
      v = fdiv(2 * m + d, 2 * d);
    end
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Place one pixel and predict the filtered center when its window completes
  task automatic take_pixel(logic [23:0] px);
    int w, h, hw, nv, col, row, side, cidx;
    longint s[3], q[3], v, n;
    logic [23:0] pv, ctr;
    filtered_px_t res;
    w  = (reg_width == 0) ? 1 : ((reg_width > LINEW) ? LINEW : reg_width);
    h  = (reg_height == 0) ? 1 : reg_height;
    hw = (reg_hw > DEF_MAX_HALF_WINDOW) ? DEF_MAX_HALF_WINDOW : reg_hw;
    nv = (reg_noise == 0) ? 1 : reg_noise;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 16'hFFFF;
    end
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    pixel_mem[(row % ROWS) * LINEW + col] = px;
    if (row >= 2 * hw && col >= 2 * hw) begin
      side = 2 * hw + 1;
      n = side * side;
      for (int k = 0; k < 3; k++) begin
        s[k] = 0;
        q[k] = 0;
      end
      for (int r = row - 2 * hw; r <= row; r++)
        for (int c = col - 2 * hw; c <= col; c++) begin
          pv = pixel_mem[(r % ROWS) * LINEW + c];
          for (int k = 0; k < 3; k++) begin
            v = (pv >> (16 - 8 * k)) & 8'hFF;
            s[k] += v;
            q[k] += v * v;
          end
        end
      cidx = ((row - hw) % ROWS) * LINEW + (col - hw);
      ctr = pixel_mem[cidx];
      res.cx = 11'(col - hw);
      res.cy = 16'(row - hw);
      res.r = lee_channel(s[0], q[0], n, ctr[23:16], nv);
      res.g = lee_channel(s[1], q[1], n, ctr[15:8], nv);
      res.b = lee_channel(s[2], q[2], n, ctr[7:0], nv);
      filtered_q.push_back(res);
    end
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  always @(posedge clk) begin
    filtered_px_t exp_px, got_px;
    if (!rst_n) begin
      col_cnt = 0;
      row_cnt = 0;
      reg_hw = 4'd2;
      reg_noise = 16'd5;
      reg_width = 12'd2048;
      reg_height = 16'd1080;
      filtered_q.delete();
      mismatches <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_HALF_WINDOW: reg_hw = cfg_data[3:0];
          CFG_NOISE_VAR:   reg_noise = cfg_data;
          CFG_IMG_WIDTH:   reg_width = cfg_data[11:0];
          CFG_IMG_HEIGHT:  reg_height = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pixel({in_red_in, in_green_in, in_blue_in});
      // result requests
      if (out_valid && !out_stall) begin
        got_px = {out_center_x, out_center_y, out_red_out, out_green_out, out_blue_out};
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got_px);
          mismatches <= mismatches + 1;
        end else begin
          exp_px = filtered_q.pop_front();
          if (exp_px !== got_px) begin
            $display("%0t: result mismatch: expected x=%0d y=%0d rgb=%0d,%0d,%0d",
                     $time, exp_px.cx, exp_px.cy, exp_px.r, exp_px.g, exp_px.b);
            $display("%0t:                  actual   x=%0d y=%0d rgb=%0d,%0d,%0d",
                     $time, got_px.cx, got_px.cy, got_px.r, got_px.g, got_px.b);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= filtered_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the adaptive MMSE window filter: directed pixels at the field
// extremes, then whole random frames under several window, noise and image
// settings, with random sender and receiver idling and a long output hold.
// ---------------------------------------------------------------------------

module tb_top;
  import amwf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HALF_WINDOW;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_center_x;
  logic [15:0] out_center_y;
  logic [7:0]  out_red_out, out_green_out, out_blue_out;
  int          mismatches, pending;
  int          tx_idle = 0, rx_idle = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  logic [23:0] frame_base;
  int          frame_style;

  always #10 clk = ~clk;

  adaptive_mmse_window_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out)
  );

  amwf_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out),
    .mismatches(mismatches), .pending(pending)
  );

  // Receiver: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(0, 99) < rx_idle);
  end

  // One pixel request; valid is left high after acceptance
  task automatic send_pixel(logic [23:0] px);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_red_in, in_green_in, in_blue_in} <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender pauses until every filtered pixel is back, then the pipe settles
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_regs(int hw, int nv, int w, int h);
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= i[1:0];
      case (i[1:0])
        CFG_HALF_WINDOW: cfg_data <= 16'(hw);
        CFG_NOISE_VAR:   cfg_data <= 16'(nv);
        CFG_IMG_WIDTH:   cfg_data <= 16'(w);
        default:         cfg_data <= 16'(h);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Frame content: uniform noise, flat color, or small noise around a base
  function automatic logic [23:0] gen_pixel();
    logic [23:0] p;
    case (frame_style)
      0: p = 24'($urandom);
      1: p = frame_base;
      default: begin
        p = frame_base;
        p[23:16] = frame_base[23:16] ^ 8'($urandom_range(0, 3));
        p[15:8]  = frame_base[15:8] ^ 8'($urandom_range(0, 3));
        p[7:0]   = frame_base[7:0] ^ 8'($urandom_range(0, 3));
      end
    endcase
    return p;
  endfunction

  task automatic send_pixels(int count);
    frame_base = 24'($urandom);
    frame_style = $urandom_range(0, 3);
    if (frame_style == 3) frame_style = 0;
    for (int i = 0; i < count; i++) send_pixel(gen_pixel());
  endtask

  task automatic send_frames(int frames, int w, int h);
    for (int f = 0; f < frames; f++) send_pixels(w * h);
  endtask

  function automatic int pick_noise();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1x1 image, zero window, zero noise and zero sizes
    set_regs(0, 0, 0, 0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hAA55AA);
    send_pixel(24'h55AA55);
    send_pixel(24'h0180FE);
    send_pixel(24'hFE0180);
    send_pixel(24'h7F807F);
    send_pixel(24'h80017F);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    drain();
    // Directed: flat 3x3 window, zero variance
    set_regs(1, 1, 3, 3);
    for (int i = 0; i < 9; i++) send_pixel(24'hC80780);
    drain();

    // Receiver idles more, sender less
    tx_idle = 35;
    rx_idle = 54;
    set_regs(2, 5, 16, 16);
    hold_req = 1'b1;
    send_frames(2, 16, 16);
    drain();
    set_regs(0, pick_noise(), 4095, 1);
    send_pixels(400);
    drain();

    // Then the other way round
    tx_idle = 54;
    rx_idle = 35;
    set_regs(15, pick_noise(), 22, 22);
    send_frames(1, 22, 22);
    drain();
    // Shrink width and height in mid frame: counters wrap to a new frame
    set_regs(1, 16, 16, 16);
    send_pixels(165);
    drain();
    set_regs(1, 65535, 4, 8);
    send_frames(2, 4, 8);
    drain();

    // No idling
    tx_idle = 0;
    rx_idle = 0;
    set_regs(3, pick_noise(), 12, 10);
    send_frames(2, 12, 10);
    drain();
    set_regs(1, 65535, 9, 65535);
    send_pixels(200);
    drain();

    if (mismatches == 0 && pending == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* files.f */
design/amwf_pkg.sv
design/amwf_ctrl.sv
design/amwf_dp.sv
design/adaptive_mmse_window_filter.sv
dv/amwf_checker.sv
dv/tb_top.sv
